// File: src/pfw_pkg.sv
// ----------------------------------------------------------------------------
// pfw_pkg
// shared types and constants of the progress fill width unit
// ----------------------------------------------------------------------------
package pfw_pkg;

  localparam int unsigned VAL_W   = 64;
  localparam int unsigned WIDTH_W = 31;
  localparam int unsigned STEPS   = WIDTH_W;

  // one pipeline stage of the running multiply-divide
  typedef struct packed {
    logic [VAL_W-1:0]   val;
    logic [VAL_W-1:0]   maxv;
    logic [WIDTH_W-1:0] width;
    logic [VAL_W-1:0]   rem;
    logic [WIDTH_W-1:0] quo;
    logic               invalid;
    logic               full;
  } stage_t;

endpackage

// File: src/pfw_req_if.sv
// ----------------------------------------------------------------------------
// pfw_req_if
// request channel: value, maximum and bar width
// ----------------------------------------------------------------------------
interface pfw_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] progress_value;
  logic [63:0] progress_maximum;
  logic [30:0] bar_width;

  modport source (output valid, progress_value, progress_maximum, bar_width,
                  input ready);
  modport sink (input valid, progress_value, progress_maximum, bar_width,
                output ready);
endinterface

// File: src/pfw_rsp_if.sv
// ----------------------------------------------------------------------------
// pfw_rsp_if
// response channel: filled column count and error flag
// ----------------------------------------------------------------------------
interface pfw_rsp_if;
  logic        valid;
  logic        ready;
  logic [30:0] filled_columns;
  logic        invalid_maximum;

  modport source (output valid, filled_columns, invalid_maximum, input ready);
  modport sink (input valid, filled_columns, invalid_maximum, output ready);
endinterface

// File: src/pfw_step.sv
// ----------------------------------------------------------------------------
// pfw_step
// one multiplier bit of the shift-and-add multiply-divide
// ----------------------------------------------------------------------------
module pfw_step
  import pfw_pkg::*;
(
  input  stage_t cur,
  input  logic   mbit,
  output stage_t nxt
);

  logic [VAL_W+1:0] t;
  logic [VAL_W+1:0] m1;
  logic [VAL_W+1:0] m2;
  logic [1:0]       k;
  logic [VAL_W+1:0] t_red;

  always_comb begin
    // remainder doubled plus the value when the multiplier bit is set, always below 3*max
    t  = {1'b0, cur.rem, 1'b0} + (mbit ? {2'b00, cur.val} : '0);
    m1 = {2'b00, cur.maxv};
    m2 = {1'b0, cur.maxv, 1'b0};
    if (t >= m2) begin
      k     = 2'd2;
      t_red = t - m2;
    end else if (t >= m1) begin
      k     = 2'd1;
      t_red = t - m1;
    end else begin
      k     = 2'd0;
      t_red = t;
    end
    nxt     = cur;
    nxt.rem = t_red[VAL_W-1:0];
    nxt.quo = {cur.quo[WIDTH_W-2:0], 1'b0} + {{(WIDTH_W-2){1'b0}}, k};
  end

endmodule

// File: src/progress_fill_width_unit.sv
// ----------------------------------------------------------------------------
// progress_fill_width_unit
// filled column count floor(min(value,max)*width/max) of a progress bar
// ----------------------------------------------------------------------------
// stages: 1 input stage and one stage per bar width bit, 31 of them
// throughput: one word per cycle; the whole pipeline holds on a response stall
// reset: rst clears all stage valid bits, payload registers are not reset
module progress_fill_width_unit
  import pfw_pkg::*;
(
  input logic       clk,
  input logic       rst,
  pfw_req_if.sink   req,
  pfw_rsp_if.source rsp
);

  // stage 0 is the input register, stage i holds the result after i bits
  stage_t            stg [0:STEPS];
  stage_t            stg_next [0:STEPS];
  logic [STEPS:0]    vld;
  logic              adv;

  // pipeline moves when the last stage is empty or being taken
  assign adv       = !vld[STEPS] || rsp.ready;
  assign req.ready = adv;

  always_comb begin
    stg_next[0].val     = (req.progress_value > req.progress_maximum) ?
                          req.progress_maximum : req.progress_value;
    stg_next[0].maxv    = req.progress_maximum;
    stg_next[0].width   = req.bar_width;
    stg_next[0].rem     = '0;
    stg_next[0].quo     = '0;
    stg_next[0].invalid = (req.progress_maximum == '0);
    // value at or above max gives the full width
    stg_next[0].full    = (req.progress_value >= req.progress_maximum);
  end

  // bits of the width go in from the top, one per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    pfw_step u_step (
      .cur  (stg[i]),
      .mbit (stg[i].width[STEPS-1-i]),
      .nxt  (stg_next[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STEPS-1:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= STEPS; i++) begin
        stg[i] <= stg_next[i];
      end
    end
  end

  assign rsp.valid           = vld[STEPS];
  assign rsp.invalid_maximum = stg[STEPS].invalid;
  assign rsp.filled_columns  = stg[STEPS].invalid ? '0 :
                               stg[STEPS].full    ? stg[STEPS].width :
                               stg[STEPS].quo;

`ifndef SYNTH
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.invalid_maximum |-> rsp.filled_columns == '0)
    else $error("invalid maximum with nonzero fill");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.filled_columns))
    else $error("stalled response word changed");
  a_reset: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("valid bits survive reset");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.filled_columns <= stg[STEPS].width)
    else $error("fill exceeds bar width");
`endif

endmodule
